// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the UART buffering engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/urb_pkg.sv =====
// Package with the types and constants of the UART buffering engine.
`timescale 1ns / 1ps

package urb_pkg;

  localparam int DATA_W      = 8;
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int MAX_RESULTS = 16;
  localparam int BURST_CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SEND     = 2'd0,
    OP_TX_EMPTY = 2'd1,
    OP_RX_BYTE  = 2'd2,
    OP_READ     = 2'd3
  } urb_op_t;

  localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TX_READ,
    S_TX_EMIT,
    S_RX_READ,
    S_RX_EMIT
  } urb_state_t;

endpackage

// ===== rtl/urb_in_if.sv =====
// Input channel interface: valid, ready and one command item.
`timescale 1ns / 1ps

interface urb_in_if import urb_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink (input valid, input opcode, input data_in, output ready);
endinterface

// ===== rtl/urb_out_if.sv =====
// Output channel interface: valid, ready and one result item.
`timescale 1ns / 1ps

interface urb_out_if import urb_pkg::*; #(parameter int LEVEL_W = 9);
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [DATA_W-1:0]  data_out;
  logic               last;
  logic [LEVEL_W-1:0] rx_level;

  modport source (output valid, output kind, output data_out, output last, output rx_level,
                  input ready);
  modport sink (input valid, input kind, input data_out, input last, input rx_level,
                output ready);
endinterface

// ===== rtl/urb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/uart_ring_buffer_tx_pump.sv =====
// Top level of the UART buffering engine with transmit and receive byte rings.
`timescale 1ns / 1ps
// The engine buffers one UART port in two byte rings held in RAM.
// Items arrive on req: send a byte, transmitter empty, received byte or read.
// Results leave on rsp: bytes for the transmitter, read data or an empty report;
// last marks the final result of an item and rx_level the receive ring fill.
// A send or a received byte is written to its ring as it is taken. A send that starts the
// transmitter, or a transmitter empty event, emits a burst: each byte is read from
// the RAM in S_TX_READ and loaded into the output register in S_TX_EMIT. A read
// passes through S_RX_READ, which reads the RAM if the ring holds a byte, and S_RX_EMIT. A full ring overwrites
// its oldest byte. fifo_present, written through cfg_wr_en and cfg_wr_data,
// allows bursts of up to BURST_MAX bytes (never more than sixteen); otherwise
// a burst is one byte. Reset empties both rings, marks the transmitter idle and
// clears fifo_present; no clearing pass is needed. When the receiver stalls,
// the result waits in the output register and the engine holds its state until
// the output register is free; items that give no result are still taken.
`include "assert_macros.svh"

module uart_ring_buffer_tx_pump import urb_pkg::*; #(
  parameter int BUF_DEPTH = 256,
  parameter int BURST_MAX = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  urb_in_if.sink    req,
  urb_out_if.source rsp
);

  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int BURST_CAP = (BURST_MAX < MAX_RESULTS) ? BURST_MAX : MAX_RESULTS;

  urb_state_t state, state_next;
  logic fifo_present;
  logic [PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [CNT_W-1:0] tx_count, tx_count_next, rx_count, rx_count_next;
  logic tx_busy, tx_busy_next;
  logic [BURST_CNT_W-1:0] remain, remain_next;
  logic last_pend, last_pend_next;
  logic rd_hit, rd_hit_next;
  logic out_valid, out_valid_next;
  logic [KIND_W-1:0] out_kind, out_kind_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic out_last, out_last_next;
  logic [CNT_W-1:0] out_level, out_level_next;
  logic slot_free;
  logic tx_we, tx_re, rx_we, rx_re;
  logic [DATA_W-1:0] tx_rdata, rx_rdata;
  logic [CNT_W-1:0] tx_fill, rx_fill;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  urb_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail),
    .wdata (req.data_in),
    .re    (tx_re),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  urb_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (req.data_in),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.kind     = out_kind;
  assign rsp.data_out = out_data;
  assign rsp.last     = out_last;
  assign rsp.rx_level = out_level;
  assign slot_free    = !out_valid || rsp.ready;

  always_comb begin
    state_next     = state;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    tx_count_next  = tx_count;
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    rx_count_next  = rx_count;
    tx_busy_next   = tx_busy;
    remain_next    = remain;
    last_pend_next = last_pend;
    rd_hit_next    = rd_hit;
    out_valid_next = out_valid && !rsp.ready;
    out_kind_next  = out_kind;
    out_data_next  = out_data;
    out_last_next  = out_last;
    out_level_next = out_level;
    tx_we = 1'b0;
    tx_re = 1'b0;
    rx_we = 1'b0;
    rx_re = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (urb_op_t'(req.opcode))
            OP_SEND: begin
              tx_we        = 1'b1;
              tx_tail_next = ptr_inc(tx_tail);
              if (tx_count == CNT_W'(BUF_DEPTH)) begin
                tx_head_next = ptr_inc(tx_head);
              end else begin
                tx_count_next = tx_count + 1'b1;
              end
              if (!tx_busy) begin
                tx_busy_next = 1'b1;
                remain_next  = fifo_present ? BURST_CNT_W'(BURST_CAP) : BURST_CNT_W'(1);
                state_next   = S_TX_READ;
              end
            end
            OP_TX_EMPTY: begin
              if (tx_count != '0) begin
                remain_next = fifo_present ? BURST_CNT_W'(BURST_CAP) : BURST_CNT_W'(1);
                state_next  = S_TX_READ;
              end else begin
                tx_busy_next = 1'b0;
              end
            end
            OP_RX_BYTE: begin
              rx_we        = 1'b1;
              rx_tail_next = ptr_inc(rx_tail);
              if (rx_count == CNT_W'(BUF_DEPTH)) begin
                rx_head_next = ptr_inc(rx_head);
              end else begin
                rx_count_next = rx_count + 1'b1;
              end
            end
            OP_READ: begin
              state_next = S_RX_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TX_READ: begin
        tx_re          = 1'b1;
        tx_head_next   = ptr_inc(tx_head);
        tx_count_next  = tx_count - 1'b1;
        last_pend_next = (remain == BURST_CNT_W'(1)) || (tx_count == CNT_W'(1));
        remain_next    = remain - 1'b1;
        state_next     = S_TX_EMIT;
      end
      S_TX_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = KIND_TX;
          out_data_next  = tx_rdata;
          out_last_next  = last_pend;
          out_level_next = rx_count;
          state_next     = last_pend ? S_IDLE : S_TX_READ;
        end
      end
      S_RX_READ: begin
        if (rx_count != '0) begin
          rx_re         = 1'b1;
          rx_head_next  = ptr_inc(rx_head);
          rx_count_next = rx_count - 1'b1;
          rd_hit_next   = 1'b1;
        end else begin
          rd_hit_next = 1'b0;
        end
        state_next = S_RX_EMIT;
      end
      S_RX_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = rd_hit ? KIND_RD : KIND_EMPTY;
          out_data_next  = rd_hit ? rx_rdata : '0;
          out_last_next  = 1'b1;
          out_level_next = rx_count;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fifo_present <= 1'b0;
      tx_head      <= '0;
      tx_tail      <= '0;
      tx_count     <= '0;
      rx_head      <= '0;
      rx_tail      <= '0;
      rx_count     <= '0;
      tx_busy      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_count  <= tx_count_next;
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_count  <= rx_count_next;
      tx_busy   <= tx_busy_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        fifo_present <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    remain    <= remain_next;
    last_pend <= last_pend_next;
    rd_hit    <= rd_hit_next;
    out_kind  <= out_kind_next;
    out_data  <= out_data_next;
    out_last  <= out_last_next;
    out_level <= out_level_next;
  end

  // Distance from head to tail, which must match the fill modulo the depth.
  assign tx_fill = (tx_tail >= tx_head) ? (CNT_W'(tx_tail) - CNT_W'(tx_head))
                 : (CNT_W'(tx_tail) + CNT_W'(BUF_DEPTH) - CNT_W'(tx_head));
  assign rx_fill = (rx_tail >= rx_head) ? (CNT_W'(rx_tail) - CNT_W'(rx_head))
                 : (CNT_W'(rx_tail) + CNT_W'(BUF_DEPTH) - CNT_W'(rx_head));

  `ASSERT_ALWAYS(a_tx_ptrs, tx_fill == ((tx_count == CNT_W'(BUF_DEPTH)) ? '0 : tx_count), "tx pointers disagree with fill")
  `ASSERT_ALWAYS(a_rx_ptrs, rx_fill == ((rx_count == CNT_W'(BUF_DEPTH)) ? '0 : rx_count), "rx pointers disagree with fill")
  `ASSERT_IMPLIES(a_pop_nonempty, state == S_TX_READ, tx_busy && (tx_count != '0), "burst pops an empty or idle ring")
  `ASSERT_IMPLIES(a_idle_empty, !tx_busy, tx_count == '0, "transmitter idle with bytes queued")

endmodule
